// File: src/ffba_pkg.sv
// ffba_pkg: shared types and codes for the first-fit block allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_FREE    = 3'd2,
    OP_DEFRAG  = 3'd3,
    OP_FREEALL = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_FND  = 2'd2;
  localparam logic [1:0] ST_MOVE     = 2'd3;

  localparam logic [6:0] HEADER_RESET = 7'd16;

  typedef struct packed {
    logic [2:0] operation;
    logic [9:0] request_bytes;
    logic [9:0] payload_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  granted_address;
    logic [9:0]  move_source;
    logic [9:0]  move_target;
    logic [10:0] move_length;
    logic        last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC_SCAN,
    S_ALLOC_SPLIT,
    S_FREE_SCAN,
    S_FREEALL,
    S_DF_SCAN,
    S_DF_PLACE,
    S_DF_TAIL,
    S_DF_COMMIT,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: src/first_fit_block_allocator.sv
// first_fit_block_allocator: top level, slot table and scan sequencer
// depends on ffba_pkg
`timescale 1ns / 1ps
`default_nettype none
// usage:
// - in channel: in_valid / in_stall / in_data beats carry one operation each
// - out channel: out_valid / out_stall / out_data beats carry one result each
// - cfg channel: cfg_valid / cfg_ready / cfg_data writes header_bytes (reset 16)
//   cfg_ready is high always; write only while idle
// - one operation at a time: in_stall is high from acceptance until its last
//   result beat is loaded into the output register
// - every scan walks the slot table one slot a cycle through one shared
//   compare unit: alloc and free scan up to TABLE_SLOTS slots, a split up
//   to TABLE_SLOTS more; init and free-all do not scan
// - defragment runs one address-order search over all TABLE_SLOTS slots per
//   used block and one more that finds none, with one move beat per moved
//   block and a final ok beat
// - stalls on out hold the result register; the sequencer waits
// - reset: synchronous, one free block covers the pool, no clearing pass
module first_fit_block_allocator #(
  parameter int POOL_BYTES  = 1024,
  parameter int TABLE_SLOTS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ffba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output ffba_pkg::out_item_t out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [6:0]          cfg_data
);
  import ffba_pkg::*;

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int AW = $clog2(POOL_BYTES + 1) + 1;  // pool arithmetic width
  localparam logic [AW-1:0] POOL = AW'(POOL_BYTES);
  localparam logic [AW-1:0] PAY_RESET =
    (POOL > AW'(HEADER_RESET)) ? POOL - AW'(HEADER_RESET) : '0;

  logic [6:0] header_bytes;

  // slot table, read through the scan index and through sel and best
  logic [TABLE_SLOTS-1:0] slot_valid, slot_free, taken;
  logic [AW-1:0] slot_offset  [TABLE_SLOTS];
  logic [AW-1:0] slot_payload [TABLE_SLOTS];
  // staging for compaction results
  logic [AW-1:0] noff [TABLE_SLOTS];
  logic [AW-1:0] npay [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] nfree;

  state_t state, state_next;
  in_item_t cur;
  logic [CW-1:0] idx;
  logic [IW-1:0] sel;     // slot found by scan
  logic [IW-1:0] best;
  logic          have_best;
  logic [CW-1:0] n;       // compaction count
  logic [AW-1:0] c;       // compaction cursor
  logic          more_moves;
  logic          out_load;
  out_item_t     res;

  logic [IW-1:0] ix;
  assign ix = idx[IW-1:0];
  logic [AW-1:0] hdr;
  assign hdr = AW'(header_bytes);

  // the shared compare unit: one slot per cycle
  logic [AW-1:0] cur_off, cur_pay, req_w, left, off_hdr;
  logic          fits, addr_hit, earlier;
  always_comb begin
    cur_off  = slot_offset[ix];
    cur_pay  = slot_payload[ix];
    req_w    = AW'(cur.request_bytes);
    left     = cur_pay - req_w;
    off_hdr  = cur_off + hdr;
    fits     = slot_valid[ix] && slot_free[ix] && (cur_pay >= req_w);
    addr_hit = slot_valid[ix] && (off_hdr == AW'(cur.payload_address));
    earlier  = slot_valid[ix] && !slot_free[ix] && !taken[ix] &&
               (!have_best || cur_off < slot_offset[best]);
  end

  logic scan_last;
  assign scan_last = (idx == CW'(TABLE_SLOTS - 1));
  logic [AW-1:0] total_best;
  assign total_best = hdr + slot_payload[best];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) header_bytes <= HEADER_RESET;
    else if (cfg_valid) header_bytes <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        case (in_data.operation)
          OP_INIT:    state_next = S_INIT;
          OP_ALLOC:   state_next = S_ALLOC_SCAN;
          OP_FREE:    state_next = S_FREE_SCAN;
          OP_DEFRAG:  state_next = S_DF_SCAN;
          OP_FREEALL: state_next = S_FREEALL;
          default:    state_next = S_EMIT;
        endcase
      end
      S_INIT, S_FREEALL: state_next = S_EMIT;
      S_ALLOC_SCAN: if (fits) begin
        state_next = (left > hdr) ? S_ALLOC_SPLIT : S_EMIT;
      end else if (scan_last) state_next = S_EMIT;
      S_ALLOC_SPLIT: if (!slot_valid[ix] || scan_last) state_next = S_EMIT;
      S_FREE_SCAN: if (addr_hit || scan_last) state_next = S_EMIT;
      S_DF_SCAN: if (scan_last) begin
        if (!(have_best || earlier)) state_next = S_DF_TAIL;
        else state_next = S_DF_PLACE;
      end
      S_DF_PLACE: if (!more_moves || !out_stall || !out_valid)
        state_next = S_DF_SCAN;
      S_DF_TAIL: state_next = S_DF_COMMIT;
      S_DF_COMMIT: state_next = S_EMIT;
      S_EMIT: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // a move beat goes out only when the block changes place
  assign more_moves = (slot_offset[best] != c);

  // output register takes a new beat when empty or being drained
  assign out_load = (!out_valid || !out_stall) &&
                    (state == S_EMIT || (state == S_DF_PLACE && more_moves));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot_valid <= TABLE_SLOTS'(1);
      slot_free <= TABLE_SLOTS'(1);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_offset[i]  <= '0;
        slot_payload[i] <= (i == 0) ? PAY_RESET : '0;
      end
      idx <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          idx <= '0; have_best <= 1'b0;
          taken <= '0; n <= '0; c <= '0;
          res <= '{status: ST_OK, granted_address: '0, move_source: '0,
                   move_target: '0, move_length: '0, last_result: 1'b1};
          if (in_valid) cur <= in_data;
        end
        S_INIT: begin
          slot_valid <= TABLE_SLOTS'(1); slot_free <= TABLE_SLOTS'(1);
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_offset[i]  <= '0;
            slot_payload[i] <= (i == 0 && POOL > hdr) ? POOL - hdr : '0;
          end
        end
        S_FREEALL: slot_free <= slot_free | slot_valid;
        S_ALLOC_SCAN: begin
          if (fits) begin
            sel <= ix;
            slot_free[ix] <= 1'b0;
            res.granted_address <= off_hdr[9:0];
            idx <= '0;
          end else begin
            idx <= idx + 1'b1;
            if (scan_last) res.status <= ST_NO_SPACE;
          end
        end
        S_ALLOC_SPLIT: begin
          if (!slot_valid[ix]) begin
            slot_valid[ix]   <= 1'b1;
            slot_free[ix]    <= 1'b1;
            slot_offset[ix]  <= slot_offset[sel] + hdr + req_w;
            slot_payload[ix] <= slot_payload[sel] - req_w - hdr;
            slot_payload[sel] <= req_w;
          end
          idx <= idx + 1'b1;
        end
        S_FREE_SCAN: begin
          if (addr_hit) slot_free[ix] <= 1'b1;
          else if (scan_last) res.status <= ST_NOT_FND;
          idx <= idx + 1'b1;
        end
        S_DF_SCAN: begin
          if (earlier) begin
            best <= ix; have_best <= 1'b1;
          end
          idx <= scan_last ? '0 : idx + 1'b1;
        end
        S_DF_PLACE: if (!more_moves || !out_valid || !out_stall) begin
          if (more_moves) begin
            out_data  <= '{status: ST_MOVE, granted_address: '0,
                           move_source: slot_offset[best][9:0],
                           move_target: c[9:0],
                           move_length: total_best[10:0],
                           last_result: 1'b0};
          end
          taken[best] <= 1'b1;
          noff[n[IW-1:0]]  <= c;
          npay[n[IW-1:0]]  <= slot_payload[best];
          nfree[n[IW-1:0]] <= 1'b0;
          n <= n + 1'b1;
          c <= c + total_best;
          have_best <= 1'b0;
        end
        S_DF_TAIL: begin
          if (n < CW'(TABLE_SLOTS) && POOL > c && (POOL - c) > hdr) begin
            noff[n[IW-1:0]]  <= c;
            npay[n[IW-1:0]]  <= POOL - c - hdr;
            nfree[n[IW-1:0]] <= 1'b1;
            n <= n + 1'b1;
          end
        end
        S_DF_COMMIT: begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (CW'(i) < n) begin
              slot_valid[i]   <= 1'b1;
              slot_free[i]    <= nfree[i];
              slot_offset[i]  <= noff[i];
              slot_payload[i] <= npay[i];
            end else begin
              slot_valid[i]   <= 1'b0;
              slot_free[i]    <= 1'b0;
              slot_offset[i]  <= '0;
              slot_payload[i] <= '0;
            end
          end
        end
        S_EMIT: if (!out_valid || !out_stall) begin
          out_data  <= res;
        end
        default: ;
      endcase
    end
  end

  // a result beat only leaves while an operation is in flight
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT || $past(state) == S_DF_PLACE)
    else $error("result beat outside an operation");
  // input taken only in idle
  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> state == S_IDLE)
    else $error("input accepted while busy");
  // a move beat is never the last one
  a_move_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_MOVE) |-> !out_data.last_result)
    else $error("move beat marked last");

endmodule
`default_nettype wire
